@@ rtl/btos_pkg.sv @@
`timescale 1ns / 1ps
package btos_pkg;

  localparam int unsigned KeyW = 42;
  localparam int unsigned PayW = 32;

  typedef enum logic [2:0] {
    ST_ORDERED  = 3'd0,
    ST_HELD     = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_REL
  } state_e;

  // Broadcast command to every pending cell
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    logic            cap;   // latch own match into sel
    logic            rel;   // free the cell latched in sel
    logic            hold;  // park or refresh an early batch
  } cell_cmd_t;

endpackage

@@ rtl/batch_total_order_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Batch total-order sequencer. Pulse start_i with a batch descriptor while
// busy_o is low. Each result appears for exactly one cycle with
// result_valid_o; the receiver cannot stall, so it must take every strobe.
// last_o marks the final result of a transaction. Steps: the
// expected-sequence RAM is read at the accepting edge, then the compare is
// registered, and then the execute step loads the output register. Each
// released batch follows in the next cycle, one per cycle. busy_o drops in
// the cycle that shows the last result, and the next transaction can be
// accepted at the edge that takes that result. Descriptors with a zero
// count or an out-of-range broker/client are taken and ignored without
// going busy. After reset the expected-sequence RAM is cleared one entry
// per cycle, which keeps busy_o high until every entry has been cleared.
module batch_total_order_sequencer_unit
  import btos_pkg::*;
#(
  parameter int unsigned BROKERS            = 16,
  parameter int unsigned CLIENTS_PER_BROKER = 64,
  parameter int unsigned PENDING_DEPTH      = 32,
  parameter int unsigned EXPORT_SLOTS       = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  broker_id_i,
  input  logic [5:0]  client_id_i,
  input  logic [31:0] batch_seq_i,
  input  logic [15:0] msg_count_i,
  input  logic [15:0] batch_ref_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [3:0]  out_broker_o,
  output logic [5:0]  out_client_o,
  output logic [31:0] out_seq_o,
  output logic [15:0] out_count_o,
  output logic [15:0] out_ref_o,
  output logic [63:0] total_order_start_o,
  output logic [63:0] broker_ordered_o,
  output logic [11:0] export_index_o,
  output logic        last_o
);

  localparam int unsigned Depth = BROKERS * CLIENTS_PER_BROKER;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned BW    = (BROKERS > 1) ? $clog2(BROKERS) : 1;
  localparam int unsigned SW    = $clog2(EXPORT_SLOTS);

  state_e state_q, state_d;

  // ---------------- transaction latch ----------------
  logic [3:0]    b_q;
  logic [5:0]    c_q;
  logic [31:0]   seq_q;
  logic [15:0]   cnt_q, ref_q;
  logic [AW-1:0] addr_q, clr_q;
  logic          eq_q, gt_q;
  logic [31:0]   rel_seq_q;
  logic [PayW-1:0] rel_pay_q;

  logic accept, in_range, take;
  assign accept   = start_i && (state_q == S_IDLE);
  assign in_range = (32'(broker_id_i) < BROKERS) && (32'(client_id_i) < CLIENTS_PER_BROKER);
  assign take     = accept && in_range && (msg_count_i != 16'd0);

  logic [AW-1:0] in_addr;
  assign in_addr = AW'(32'(broker_id_i) * CLIENTS_PER_BROKER + 32'(client_id_i));

  // ---------------- expected-sequence RAM ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata, ram_rdata;

  btos_ram #(.WIDTH(32), .DEPTH(Depth), .AW(AW)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------- per-broker counters ----------------
  logic [63:0]   ordered_q [BROKERS];
  logic [SW-1:0] slot_q    [BROKERS];
  logic [63:0]   total_q;

  logic [BW+3:0] b_ext;
  logic [BW-1:0] bidx;
  assign b_ext = {{BW{1'b0}}, b_q};
  assign bidx  = b_ext[BW-1:0];

  // Batch being ordered this cycle: the new one in EXEC, a held one in REL
  logic        do_order;
  logic [31:0] ord_seq;
  logic [15:0] ord_cnt, ord_ref;
  assign do_order = ((state_q == S_EXEC) && eq_q) || (state_q == S_REL);
  assign ord_seq  = (state_q == S_REL) ? rel_seq_q : seq_q;
  assign ord_cnt  = (state_q == S_REL) ? rel_pay_q[31:16] : cnt_q;
  assign ord_ref  = (state_q == S_REL) ? rel_pay_q[15:0] : ref_q;

  logic [63:0] ordered_next;
  logic [SW:0] slot_inc;
  logic [SW-1:0] slot_next;
  logic [SW+11:0] slot_ext;
  assign ordered_next = ordered_q[bidx] + 64'(ord_cnt);
  assign slot_inc     = {1'b0, slot_q[bidx]} + (SW+1)'(1);
  assign slot_next    = (slot_inc >= (SW+1)'(EXPORT_SLOTS)) ? '0 : slot_inc[SW-1:0];
  assign slot_ext     = {12'd0, slot_q[bidx]};

  // ---------------- pending cell chain ----------------
  // Search key: the early batch itself when parking, otherwise the next
  // sequence after the batch being ordered (lookahead for release and last).
  cell_cmd_t cmd;
  logic [31:0] key_seq;
  assign key_seq   = ((state_q == S_EXEC) && gt_q) ? seq_q : ord_seq + 32'd1;
  assign cmd.key   = {b_q, c_q, key_seq};
  assign cmd.pay   = {cnt_q, ref_q};
  assign cmd.cap   = do_order;
  assign cmd.rel   = (state_q == S_REL);
  assign cmd.hold  = (state_q == S_EXEC) && gt_q;

  logic            hit_c  [PENDING_DEPTH+1];
  logic            free_c [PENDING_DEPTH+1];
  logic [PayW-1:0] pay_c  [PENDING_DEPTH+1];
  logic            hit_all, free_any;

  assign hit_c[0]  = 1'b0;
  assign free_c[0] = 1'b0;
  assign pay_c[0]  = '0;
  assign hit_all   = hit_c[PENDING_DEPTH];
  assign free_any  = free_c[PENDING_DEPTH];

  for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
    btos_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .hit_all_i (hit_all),
      .free_i    (free_c[g]),
      .free_o    (free_c[g+1]),
      .hit_i     (hit_c[g]),
      .hit_o     (hit_c[g+1]),
      .pay_i     (pay_c[g]),
      .pay_o     (pay_c[g+1])
    );
  end

  // ---------------- FSM: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE:  if (take) state_d = S_CMP;
      S_CMP:   state_d = S_EXEC;
      S_EXEC:  state_d = (eq_q && hit_all) ? S_REL : S_IDLE;
      S_REL:   state_d = hit_all ? S_REL : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- FSM: outputs ----------------
  logic        res_en;
  status_e     res_status;
  logic        res_last;
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = ord_seq + 32'd1;
    res_en     = 1'b0;
    res_status = ST_DUP;
    res_last   = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_EXEC: begin
        res_en = 1'b1;
        if (eq_q) begin
          ram_we     = 1'b1;
          res_status = ST_ORDERED;
          res_last   = !hit_all;
        end else if (gt_q) begin
          res_status = (hit_all || free_any) ? ST_HELD : ST_FULL;
        end else begin
          res_status = ST_DUP;
        end
      end
      S_REL: begin
        ram_we     = 1'b1;
        res_en     = 1'b1;
        res_status = ST_RELEASED;
        res_last   = !hit_all;
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      total_q        <= '0;
      result_valid_o <= 1'b0;
      for (int i = 0; i < BROKERS; i++) begin
        ordered_q[i] <= '0;
        slot_q[i]    <= '0;
      end
    end else begin
      state_q        <= state_d;
      result_valid_o <= res_en;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (do_order) begin
        total_q         <= total_q + 64'(ord_cnt);
        ordered_q[bidx] <= ordered_next;
        slot_q[bidx]    <= slot_next;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (take) begin
      b_q    <= broker_id_i;
      c_q    <= client_id_i;
      seq_q  <= batch_seq_i;
      cnt_q  <= msg_count_i;
      ref_q  <= batch_ref_i;
      addr_q <= in_addr;
    end
    if (state_q == S_CMP) begin
      eq_q <= (seq_q == ram_rdata);
      gt_q <= (seq_q > ram_rdata);
    end
    if (do_order) begin
      rel_seq_q <= ord_seq + 32'd1;
      rel_pay_q <= pay_c[PENDING_DEPTH];
    end
    if (res_en) begin
      status_o     <= res_status;
      out_broker_o <= b_q;
      out_client_o <= c_q;
      out_seq_o    <= ord_seq;
      out_count_o  <= ord_cnt;
      out_ref_o    <= ord_ref;
      last_o       <= res_last;
      if (do_order) begin
        total_order_start_o <= total_q;
        broker_ordered_o    <= ordered_next;
        export_index_o      <= slot_ext[11:0];
      end else begin
        total_order_start_o <= '0;
        broker_ordered_o    <= '0;
        export_index_o      <= '0;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ rtl/btos_ram.sv @@
`timescale 1ns / 1ps
module btos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/btos_cell.sv @@
`timescale 1ns / 1ps
module btos_cell
  import btos_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic            hit_all_i,
  input  logic            free_i,
  output logic            free_o,
  input  logic            hit_i,
  output logic            hit_o,
  input  logic [PayW-1:0] pay_i,
  output logic [PayW-1:0] pay_o
);

  logic            valid_q, sel_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;
  logic            match, take_free;

  assign match     = valid_q && (key_q == cmd_i.key);
  assign take_free = !valid_q && !free_i;   // first free cell in the row
  assign free_o    = free_i | !valid_q;
  assign hit_o     = hit_i | match;
  assign pay_o     = pay_i | (match ? pay_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        sel_q <= match;
      end
      if (cmd_i.rel && sel_q) begin
        valid_q <= 1'b0;
      end
      if (cmd_i.hold && !hit_all_i && take_free) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      if (match) begin
        pay_q <= cmd_i.pay;
      end else if (!hit_all_i && take_free) begin
        key_q <= cmd_i.key;
        pay_q <= cmd_i.pay;
      end
    end
  end

endmodule

@@ rtl/btos_checker.sv @@
`timescale 1ns / 1ps
module btos_checker
  import btos_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [2:0]  status_o,
  input logic [31:0] out_seq_o,
  input logic [63:0] total_order_start_o,
  input logic [11:0] export_index_o,
  input logic        last_o
);

  // Releases stream back to back until the last one
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("result chain broken before last");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == ST_HELD || status_o == ST_DUP || status_o == ST_FULL)
      |-> last_o && total_order_start_o == 64'd0 && export_index_o == 12'd0)
    else $error("unordered result not final or not zeroed");

  a_rel_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_RELEASED
      |-> $past(result_valid_o) && out_seq_o == $past(out_seq_o) + 32'd1)
    else $error("released batch out of sequence");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("still busy after last result");

endmodule

bind batch_total_order_sequencer_unit btos_checker u_btos_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .busy_o              (busy_o),
  .result_valid_o      (result_valid_o),
  .status_o            (status_o),
  .out_seq_o           (out_seq_o),
  .total_order_start_o (total_order_start_o),
  .export_index_o      (export_index_o),
  .last_o              (last_o)
);
